[hdl/flat_wall_scanline_renderer_top_macros.svh]
// assertion helpers for the scanline renderer
`ifndef FLAT_WALL_SCANLINE_RENDERER_TOP_MACROS_SVH
`define FLAT_WALL_SCANLINE_RENDERER_TOP_MACROS_SVH

// same-cycle implication
`define FWSR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwsr assertion failed");

// next-cycle implication
`define FWSR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwsr assertion failed");

`endif

[hdl/fwsr_pkg.sv]
package fwsr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;

  localparam int X_W = $clog2(SCREEN_WIDTH);
  localparam int Y_W = $clog2(SCREEN_HEIGHT);

  localparam int COL_DEPTH = 2 * SCREEN_WIDTH;
  localparam int COL_AW    = $clog2(COL_DEPTH);

  localparam int OVL_BANK_BYTES = (((SCREEN_HEIGHT + 1) / 2) * SCREEN_WIDTH + 7) / 8;
  localparam int OVL_DEPTH      = 2 * OVL_BANK_BYTES;
  localparam int OVL_AW         = $clog2(OVL_DEPTH);
  localparam int OVL_PIX_W      = $clog2(((SCREEN_HEIGHT + 1) / 2) * SCREEN_WIDTH);

  localparam logic [7:0] OFFSET_START = 8'(128 - SCREEN_HEIGHT / 2);

  typedef enum logic [1:0] {
    CMD_WR_COLUMN  = 2'd0,
    CMD_WR_ROW     = 2'd1,
    CMD_WR_OVERLAY = 2'd2,
    CMD_RENDER     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_BANK    = 2'd0,
    REG_OVERLAY_COLOUR = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       bank;
    logic [9:0] index;
    logic [7:0] height;
    logic [7:0] colour;
    logic [7:0] overlay_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pixel_x;
    logic [6:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] data;
  } cfg_req_t;

  // 3-bit channel scaled to 0..255, rounded down
  function automatic logic [7:0] expand3(input logic [2:0] v);
    logic [7:0] r;
    unique case (v)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd36;
      3'd2:    r = 8'd72;
      3'd3:    r = 8'd109;
      3'd4:    r = 8'd145;
      3'd5:    r = 8'd182;
      3'd6:    r = 8'd218;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] expand2(input logic [1:0] v);
    logic [7:0] r;
    unique case (v)
      2'd0:    r = 8'd0;
      2'd1:    r = 8'd85;
      2'd2:    r = 8'd170;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

endpackage

[hdl/fwsr_in_if.sv]
interface fwsr_in_if import fwsr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/fwsr_out_if.sv]
interface fwsr_out_if import fwsr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/fwsr_cfg_if.sv]
interface fwsr_cfg_if import fwsr_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/flat_wall_scanline_renderer_top.sv]
// Untextured raycaster pixel generator. Requests 0..2 write the column store (height and
// colour per column, two banks), the per-row background store and the one-bit overlay map
// (two banks, half vertical resolution); request 3 emits the next pixel in raster order as
// 8-bit RGB with frame_end on the last pixel. One request is taken every clock while the
// output is not stalled; a pixel passes through the registered reads of the three stores
// and then the output register. Stores hold no reset value and must be written before
// they are rendered. The configuration port is always ready; register 0 selects the bank
// rendered, register 1 the overlay colour.
`include "flat_wall_scanline_renderer_top_macros.svh"

module flat_wall_scanline_renderer_top import fwsr_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  fwsr_in_if.sink     in_ch,
  fwsr_out_if.source  out_ch,
  fwsr_cfg_if.sink    cfg_ch
);

  logic            active_bank_r;
  logic [7:0]      overlay_colour_r;

  logic [X_W-1:0]  scan_x_r, scan_x_nxt;
  logic [Y_W-1:0]  scan_y_r, scan_y_nxt;
  logic [7:0]      row_offset_r, row_offset_nxt;

  logic            s1_valid_r;
  logic [X_W-1:0]  s1_x_r;
  logic [Y_W-1:0]  s1_y_r;
  logic [7:0]      s1_offset_r;
  logic            s1_last_r;

  logic [15:0]     col_mem [COL_DEPTH];
  logic [7:0]      row_mem [SCREEN_HEIGHT];
  logic [7:0]      ovl_mem [OVL_DEPTH];
  logic [15:0]     col_rd_r;
  logic [7:0]      row_rd_r;
  logic [7:0]      ovl_rd_r;

  logic            out_valid_r;
  out_item_t       out_item_r;

  in_item_t        item;
  logic            s1_adv, in_ready, in_acc, render_acc;
  logic            col_we, row_we, ovl_we;
  logic [COL_AW-1:0]    col_wr_addr, col_rd_addr;
  logic [Y_W-1:0]       row_wr_addr;
  logic [OVL_AW-1:0]    ovl_wr_addr, ovl_rd_addr;
  logic [OVL_PIX_W-1:0] ovl_pix;
  logic            x_last, y_last;
  logic [7:0]      wall_sum;
  logic [7:0]      pix_colour;
  out_item_t       out_item_nxt;

  assign item       = in_ch.payload;
  assign s1_adv     = !out_valid_r || out_ch.ready;
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_ready;
  assign in_acc     = in_ch.valid && in_ready;
  assign render_acc = in_acc && (item.cmd == CMD_RENDER);

  assign col_we = in_acc && (item.cmd == CMD_WR_COLUMN) && (32'(item.index) < SCREEN_WIDTH);
  assign row_we = in_acc && (item.cmd == CMD_WR_ROW) && (32'(item.index) < SCREEN_HEIGHT);
  assign ovl_we = in_acc && (item.cmd == CMD_WR_OVERLAY) &&
                  (32'(item.index) < OVL_BANK_BYTES);

  assign col_wr_addr = COL_AW'(item.bank) * COL_AW'(SCREEN_WIDTH) + COL_AW'(item.index);
  assign col_rd_addr = COL_AW'(active_bank_r) * COL_AW'(SCREEN_WIDTH) + COL_AW'(scan_x_r);
  assign row_wr_addr = Y_W'(item.index);
  assign ovl_pix     = OVL_PIX_W'(scan_y_r >> 1) * OVL_PIX_W'(SCREEN_WIDTH) +
                       OVL_PIX_W'(scan_x_r);
  assign ovl_wr_addr = OVL_AW'(item.bank) * OVL_AW'(OVL_BANK_BYTES) + OVL_AW'(item.index);
  assign ovl_rd_addr = OVL_AW'(active_bank_r) * OVL_AW'(OVL_BANK_BYTES) +
                       OVL_AW'(ovl_pix >> 3);

  // stores
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wr_addr] <= {item.colour, item.height};
    end
    if (render_acc) begin
      col_rd_r <= col_mem[col_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wr_addr] <= item.colour;
    end
    if (render_acc) begin
      row_rd_r <= row_mem[scan_y_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ovl_we) begin
      ovl_mem[ovl_wr_addr] <= item.overlay_byte;
    end
    if (render_acc) begin
      ovl_rd_r <= ovl_mem[ovl_rd_addr];
    end
  end

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bank_r    <= 1'b0;
      overlay_colour_r <= 8'd0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        REG_ACTIVE_BANK:    active_bank_r    <= cfg_ch.payload.data[0];
        REG_OVERLAY_COLOUR: overlay_colour_r <= cfg_ch.payload.data;
        default: ;
      endcase
    end
  end

  // raster position
  assign x_last = (scan_x_r == X_W'(SCREEN_WIDTH - 1));
  assign y_last = (scan_y_r == Y_W'(SCREEN_HEIGHT - 1));

  always_comb begin
    scan_x_nxt     = scan_x_r;
    scan_y_nxt     = scan_y_r;
    row_offset_nxt = row_offset_r;
    if (render_acc) begin
      if (x_last) begin
        scan_x_nxt = '0;
        if (y_last) begin
          scan_y_nxt     = '0;
          row_offset_nxt = OFFSET_START;
        end else begin
          scan_y_nxt = scan_y_r + Y_W'(1);
          if (scan_y_r >= Y_W'(SCREEN_HEIGHT / 2)) begin
            row_offset_nxt = row_offset_r - 8'd1;
          end else begin
            row_offset_nxt = row_offset_r + 8'd1;
          end
        end
      end else begin
        scan_x_nxt = scan_x_r + X_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_x_r     <= '0;
      scan_y_r     <= '0;
      row_offset_r <= OFFSET_START;
    end else begin
      scan_x_r     <= scan_x_nxt;
      scan_y_r     <= scan_y_nxt;
      row_offset_r <= row_offset_nxt;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (render_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (render_acc) begin
      s1_x_r      <= scan_x_r;
      s1_y_r      <= scan_y_r;
      s1_offset_r <= row_offset_r;
      s1_last_r   <= x_last && y_last;
    end
  end

  // pixel colour
  assign wall_sum = col_rd_r[7:0] + s1_offset_r;

  always_comb begin
    pix_colour = wall_sum[7] ? col_rd_r[15:8] : row_rd_r;
    if (ovl_rd_r[s1_x_r[2:0]]) begin
      pix_colour = overlay_colour_r;
    end
    out_item_nxt.pixel_x   = 7'(s1_x_r);
    out_item_nxt.pixel_y   = 7'(s1_y_r);
    out_item_nxt.red       = expand3(pix_colour[2:0]);
    out_item_nxt.green     = expand3(pix_colour[5:3]);
    out_item_nxt.blue      = expand2(pix_colour[7:6]);
    out_item_nxt.frame_end = s1_last_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  `FWSR_ASSERT_IMP(a_frame_end_pos, out_valid_r && out_item_r.frame_end, (out_item_r.pixel_x == 7'(SCREEN_WIDTH - 1)) && (out_item_r.pixel_y == 7'(SCREEN_HEIGHT - 1)))
  `FWSR_ASSERT_IMP(a_offset_at_origin, (scan_x_r == '0) && (scan_y_r == '0), row_offset_r == OFFSET_START)
  `FWSR_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r)
  `FWSR_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_ready)

endmodule

[bench/tb_flat_wall_scanline_renderer_top.sv]
module tb_flat_wall_scanline_renderer_top import fwsr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_ITEMS    = 300;
  localparam int RANDOM_PHASES   = 5;
  // renders stay within the first rows, so only the leading overlay bytes are read
  localparam int OVL_FILL_BYTES  = 32;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_MOSTLY,
    RX_EVERY_THIRD
  } rx_mode_t;

  logic clk;
  logic rst_n;

  fwsr_in_if  req_if ();
  fwsr_out_if pix_if ();
  fwsr_cfg_if cfg_if ();

  flat_wall_scanline_renderer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (pix_if),
    .cfg_ch (cfg_if)
  );

  // shadow of the renderer state
  logic [7:0] wall_height [2][SCREEN_WIDTH];
  logic [7:0] wall_colour [2][SCREEN_WIDTH];
  logic [7:0] row_colour [SCREEN_HEIGHT];
  logic [7:0] overlay_map [2][OVL_BANK_BYTES];
  int         scan_x = 0;
  int         scan_y = 0;
  logic [7:0] row_offset = OFFSET_START;
  logic       active_bank = 1'b0;
  logic [7:0] overlay_colour = 8'd0;

  out_item_t  pending_pixels [$];
  int         mismatch_count = 0;

  int         burst_left = 0;
  bit         sender_steady = 1'b0;
  bit         long_hold_req = 1'b0;

  int         rx_hold_left = 0;
  int         rx_mode_left = 0;
  int         rx_tick = 0;
  rx_mode_t   rx_mode = RX_FREE;
  int         idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] scale3(input logic [2:0] v);
    return 8'((int'(v) * 255) / 7);
  endfunction

  task automatic apply_request(input in_item_t rq);
    logic [7:0] c;
    logic [7:0] sum;
    logic [7:0] ov;
    int         oidx;
    out_item_t  px;
    case (rq.cmd)
      CMD_WR_COLUMN: begin
        if (rq.index < SCREEN_WIDTH) begin
          wall_height[rq.bank][rq.index[X_W-1:0]] = rq.height;
          wall_colour[rq.bank][rq.index[X_W-1:0]] = rq.colour;
        end
      end
      CMD_WR_ROW: begin
        if (rq.index < SCREEN_HEIGHT) row_colour[rq.index[Y_W-1:0]] = rq.colour;
      end
      CMD_WR_OVERLAY: begin
        if (rq.index < OVL_BANK_BYTES) overlay_map[rq.bank][rq.index] = rq.overlay_byte;
      end
      CMD_RENDER: begin
        c    = wall_colour[active_bank][scan_x];
        sum  = wall_height[active_bank][scan_x] + row_offset;
        oidx = ((scan_y >> 1) * SCREEN_WIDTH + scan_x) >> 3;
        ov   = overlay_map[active_bank][oidx];
        if (!sum[7]) c = row_colour[scan_y];
        if (ov[scan_x % 8]) c = overlay_colour;
        px.pixel_x   = 7'(scan_x);
        px.pixel_y   = 7'(scan_y);
        px.red       = scale3(c[2:0]);
        px.green     = scale3(c[5:3]);
        px.blue      = 8'(int'(c[7:6]) * 85);
        px.frame_end = 1'b0;
        scan_x++;
        if (scan_x >= SCREEN_WIDTH) begin
          scan_x = 0;
          scan_y++;
          if (scan_y >= SCREEN_HEIGHT / 2 + 1) row_offset--;
          else row_offset++;
          if (scan_y >= SCREEN_HEIGHT) begin
            scan_y       = 0;
            row_offset   = OFFSET_START;
            px.frame_end = 1'b1;
          end
        end
        pending_pixels.push_back(px);
      end
    endcase
  endtask

  function automatic in_item_t make_request(input cmd_t c, input logic b, input int idx,
                                            input int h, input int col, input int ob);
    in_item_t rq;
    rq.cmd          = c;
    rq.bank         = b;
    rq.index        = 10'(idx);
    rq.height       = 8'(h);
    rq.colour       = 8'(col);
    rq.overlay_byte = 8'(ob);
    return rq;
  endfunction

  function automatic in_item_t random_request(input cmd_t c);
    in_item_t rq;
    int       span;
    case (c)
      CMD_WR_COLUMN: span = SCREEN_WIDTH;
      CMD_WR_ROW:    span = SCREEN_HEIGHT;
      default:       span = OVL_BANK_BYTES;
    endcase
    rq.cmd          = c;
    rq.bank         = 1'($urandom_range(0, 1));
    rq.index        = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                                  : 10'($urandom_range(0, span - 1));
    rq.height       = 8'($urandom);
    rq.colour       = 8'($urandom);
    rq.overlay_byte = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    return rq;
  endfunction

  function automatic cmd_t random_cmd();
    if ($urandom_range(0, 9) < 6) return CMD_RENDER;
    return cmd_t'($urandom_range(0, 2));
  endfunction

  task automatic send_request(input in_item_t rq);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk); while (!req_if.ready);
    apply_request(rq);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t reg_sel, input logic [7:0] value);
    cfg_if.valid         <= 1'b1;
    cfg_if.payload.index <= reg_sel;
    cfg_if.payload.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (reg_sel)
      REG_ACTIVE_BANK:    active_bank = value[0];
      REG_OVERLAY_COLOUR: overlay_colour = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_fill_stores();
    in_item_t rq;
    sender_steady = 1'b1;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < SCREEN_WIDTH; i++) begin
        rq = random_request(CMD_WR_COLUMN);
        rq.bank  = 1'(b);
        rq.index = 10'(i);
        send_request(rq);
      end
    end
    for (int i = 0; i < SCREEN_HEIGHT; i++) begin
      rq = random_request(CMD_WR_ROW);
      rq.index = 10'(i);
      send_request(rq);
    end
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < OVL_FILL_BYTES; i++) begin
        rq = random_request(CMD_WR_OVERLAY);
        rq.bank  = 1'(b);
        rq.index = 10'(i);
        send_request(rq);
      end
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_edge_cases();
    wait_drained();
    write_register(REG_ACTIVE_BANK, 8'h00);
    write_register(REG_OVERLAY_COLOUR, 8'hFF);
    send_request(make_request(CMD_WR_COLUMN, 1'b0, 0, 255, 255, 0));
    send_request(make_request(CMD_WR_COLUMN, 1'b0, 1, 0, 0, 0));
    send_request(make_request(CMD_WR_COLUMN, 1'b0, 2, 64, 8'hC7, 0));
    send_request(make_request(CMD_WR_COLUMN, 1'b0, 3, 191, 8'h3F, 0));
    // out of range, must not alias into the other bank
    send_request(make_request(CMD_WR_COLUMN, 1'b0, SCREEN_WIDTH, 0, 8'hAA, 0));
    send_request(make_request(CMD_WR_COLUMN, 1'b1, 1023, 255, 255, 255));
    send_request(make_request(CMD_WR_ROW, 1'b0, 0, 0, 8'h38, 0));
    send_request(make_request(CMD_WR_ROW, 1'b1, SCREEN_HEIGHT - 1, 255, 8'hC0, 0));
    send_request(make_request(CMD_WR_ROW, 1'b0, SCREEN_HEIGHT, 0, 8'hFF, 0));
    send_request(make_request(CMD_WR_ROW, 1'b1, 1023, 0, 8'h07, 0));
    send_request(make_request(CMD_WR_OVERLAY, 1'b0, 0, 0, 0, 8'h10));
    send_request(make_request(CMD_WR_OVERLAY, 1'b1, OVL_BANK_BYTES - 1, 0, 0, 8'hFF));
    send_request(make_request(CMD_WR_OVERLAY, 1'b0, OVL_BANK_BYTES - 1, 0, 0, 8'h00));
    repeat (6) send_request(make_request(CMD_RENDER, 1'b0, 0, 0, 0, 0));
    wait_drained();
    write_register(REG_OVERLAY_COLOUR, 8'h00);
    repeat (3) send_request(make_request(CMD_RENDER, 1'b1, 1023, 255, 255, 255));
  endtask

  task automatic test_random_mix();
    logic [7:0] oc;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       oc = 8'h00;
        1:       oc = 8'hFF;
        default: oc = 8'($urandom);
      endcase
      write_register(REG_ACTIVE_BANK, 8'($urandom_range(0, 1)));
      write_register(REG_OVERLAY_COLOUR, oc);
      if (phase == 3) long_hold_req = 1'b1;
      repeat (RANDOM_ITEMS / RANDOM_PHASES) send_request(random_request(random_cmd()));
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel without pending request: x %0d y %0d",
               pix_if.payload.pixel_x, pix_if.payload.pixel_y);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", 8'(want.pixel_x), 8'(pix_if.payload.pixel_x));
        check_field("pixel_y", 8'(want.pixel_y), 8'(pix_if.payload.pixel_y));
        check_field("red", want.red, pix_if.payload.red);
        check_field("green", want.green, pix_if.payload.green);
        check_field("blue", want.blue, pix_if.payload.blue);
        check_field("frame_end", 8'(want.frame_end), 8'(pix_if.payload.frame_end));
      end
    end
  end

  // output stall pattern
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold_left  = HOLD_OFF_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pix_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   pix_if.ready <= 1'b1;
        RX_COIN:   pix_if.ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: pix_if.ready <= ($urandom_range(0, 4) != 0);
        default:   pix_if.ready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_stores();
    test_edge_cases();
    test_random_mix();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[flat_wall_scanline_renderer_top.f]
+incdir+hdl
hdl/fwsr_pkg.sv
hdl/fwsr_in_if.sv
hdl/fwsr_out_if.sv
hdl/fwsr_cfg_if.sv
hdl/flat_wall_scanline_renderer_top.sv
bench/tb_flat_wall_scanline_renderer_top.sv
